>>> rtl/core/ast_pkg.sv
// Shared types, constants and the factory response table for the accel self-test evaluator.
package ast_pkg;

  // Field and state widths
  localparam int ACC_W  = 16;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 12;
  localparam int TRIM_W = 8;
  localparam int CODE_W = 5;
  localparam int FT_W   = 12;
  localparam int TOL_W  = 15;
  localparam int CHG_W  = 16;
  localparam int AVG_W  = 17;
  localparam int DIFF_W = 18;
  localparam int DIV_W  = 32;
  localparam int Q_FRAC = 12;

  localparam int MAX_SAMPLES_DEF = 2048;
  localparam logic [TOL_W-1:0] TOL_RESET = 15'd573;

  // Request function codes
  localparam logic [1:0] FUNC_TEST = 2'd0;
  localparam logic [1:0] FUNC_NORM = 2'd1;
  localparam logic [1:0] FUNC_EVAL = 2'd2;

  // Top to lane control
  typedef struct packed {
    logic acc_test;
    logic acc_norm;
    logic start;
    logic take;
  } lane_ctrl_t;

  // Lane to merge status
  typedef struct packed {
    logic                    done;
    logic                    pass;
    logic signed [CHG_W-1:0] change;
  } lane_status_t;

  // Factory self-test response in LSB per trim code; code 0 has no trim
  function automatic logic [FT_W-1:0] ft_lookup(input logic [CODE_W-1:0] code);
    case (code)
      5'd1:    return 12'd1393;
      5'd2:    return 12'd1440;
      5'd3:    return 12'd1488;
      5'd4:    return 12'd1538;
      5'd5:    return 12'd1590;
      5'd6:    return 12'd1644;
      5'd7:    return 12'd1699;
      5'd8:    return 12'd1757;
      5'd9:    return 12'd1816;
      5'd10:   return 12'd1877;
      5'd11:   return 12'd1941;
      5'd12:   return 12'd2006;
      5'd13:   return 12'd2074;
      5'd14:   return 12'd2144;
      5'd15:   return 12'd2216;
      5'd16:   return 12'd2291;
      5'd17:   return 12'd2368;
      5'd18:   return 12'd2448;
      5'd19:   return 12'd2531;
      5'd20:   return 12'd2616;
      5'd21:   return 12'd2704;
      5'd22:   return 12'd2795;
      5'd23:   return 12'd2890;
      5'd24:   return 12'd2987;
      5'd25:   return 12'd3088;
      5'd26:   return 12'd3192;
      5'd27:   return 12'd3300;
      5'd28:   return 12'd3411;
      5'd29:   return 12'd3526;
      5'd30:   return 12'd3645;
      5'd31:   return 12'd3768;
      default: return 12'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/ast_sample_if.sv
// Sample and evaluate request channel.
interface ast_sample_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [ast_pkg::ACC_W-1:0]  accel_x;
  logic signed [ast_pkg::ACC_W-1:0]  accel_y;
  logic signed [ast_pkg::ACC_W-1:0]  accel_z;
  logic [ast_pkg::TRIM_W-1:0]        trim_byte_x;
  logic [ast_pkg::TRIM_W-1:0]        trim_byte_y;
  logic [ast_pkg::TRIM_W-1:0]        trim_byte_z;
  logic [ast_pkg::TRIM_W-1:0]        trim_byte_shared;

  modport source (output valid, func, accel_x, accel_y, accel_z,
                  trim_byte_x, trim_byte_y, trim_byte_z, trim_byte_shared,
                  input ready);
  modport sink (input valid, func, accel_x, accel_y, accel_z,
                trim_byte_x, trim_byte_y, trim_byte_z, trim_byte_shared,
                output ready);
endinterface

>>> rtl/core/ast_result_if.sv
// Self-test result channel.
interface ast_result_if;
  logic                             valid;
  logic                             ready;
  logic                             pass_x;
  logic                             pass_y;
  logic                             pass_z;
  logic signed [ast_pkg::CHG_W-1:0] change_x;
  logic signed [ast_pkg::CHG_W-1:0] change_y;
  logic signed [ast_pkg::CHG_W-1:0] change_z;

  modport source (output valid, pass_x, pass_y, pass_z, change_x, change_y, change_z,
                  input ready);
  modport sink (input valid, pass_x, pass_y, pass_z, change_x, change_y, change_z,
                output ready);
endinterface

>>> rtl/core/accel_self_test_evaluator_core.sv
// Accel self-test evaluator top level: phase counters, tolerance register, three lanes, merge.
//
// Sample requests (func 0 self-test on, func 1 normal, func 3 ignored) are taken
// one per cycle and add into per-axis phase sums until a phase holds MAX_SAMPLES
// samples. An evaluate request (func 2) runs three axis lanes in parallel; each
// lane uses its own one-bit-per-cycle divider for the test average, the normal
// average and the Q12 relative change in turn, and requests are held off until
// the result has been loaded into the output register. Sums and counts clear
// when the result is loaded. The Q12 tolerance is written through cfg_we/cfg_wdata
// and resets to 573 (about 14 percent).
module accel_self_test_evaluator_core #(
  parameter int MAX_SAMPLES = ast_pkg::MAX_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  ast_sample_if.sink                  sample,
  ast_result_if.source                result,
  input  logic                        cfg_we,
  input  logic [ast_pkg::TOL_W-1:0]   cfg_wdata
);
  import ast_pkg::*;

  logic                    busy;
  logic [TOL_W-1:0]        tolerance;
  logic [CNT_W-1:0]        test_count;
  logic [CNT_W-1:0]        normal_count;
  logic                    accept;
  logic                    test_room;
  logic                    norm_room;
  logic                    take;
  lane_ctrl_t              ctrl;
  lane_status_t [2:0]      st;
  logic signed [ACC_W-1:0] accel [3];
  logic [CODE_W-1:0]       code [3];

  assign sample.ready = !busy;
  assign accept       = sample.valid && sample.ready;
  assign test_room    = (test_count < CNT_W'(MAX_SAMPLES));
  assign norm_room    = (normal_count < CNT_W'(MAX_SAMPLES));

  // Lane control
  always_comb begin
    ctrl.acc_test = accept && (sample.func == FUNC_TEST) && test_room;
    ctrl.acc_norm = accept && (sample.func == FUNC_NORM) && norm_room;
    ctrl.start    = accept && (sample.func == FUNC_EVAL);
    ctrl.take     = take;
  end

  // Per-axis samples and trim codes
  always_comb begin
    accel[0] = sample.accel_x;
    accel[1] = sample.accel_y;
    accel[2] = sample.accel_z;
    code[0]  = {sample.trim_byte_x[7:5], sample.trim_byte_shared[5:4]};
    code[1]  = {sample.trim_byte_y[7:5], sample.trim_byte_shared[3:2]};
    code[2]  = {sample.trim_byte_z[7:5], sample.trim_byte_shared[1:0]};
  end

  // Busy flag, phase counters and tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      tolerance    <= TOL_RESET;
      test_count   <= '0;
      normal_count <= '0;
    end else begin
      if (cfg_we) begin
        tolerance <= cfg_wdata;
      end
      if (ctrl.acc_test) begin
        test_count <= test_count + 1'b1;
      end
      if (ctrl.acc_norm) begin
        normal_count <= normal_count + 1'b1;
      end
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (take) begin
        busy         <= 1'b0;
        test_count   <= '0;
        normal_count <= '0;
      end
    end
  end

  // Axis lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ast_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .accel        (accel[i]),
      .code         (code[i]),
      .test_count   (test_count),
      .normal_count (normal_count),
      .tolerance    (tolerance),
      .status       (st[i])
    );
  end

  ast_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .st     (st),
    .take   (take),
    .result (result)
  );

  // Lanes run in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (st[0].done == st[1].done) && (st[0].done == st[2].done))
    else $error("axis lanes out of step");

  // A result is only loaded for an evaluate in progress
  a_take_busy: assert property (@(posedge clk) disable iff (rst) take |-> busy)
    else $error("result loaded while not evaluating");

  // Counts clear once the result is loaded
  a_clear: assert property (@(posedge clk) disable iff (rst)
    take |=> (test_count == '0) && (normal_count == '0))
    else $error("phase counts not cleared");

  // Counts never pass the sample limit
  a_limit: assert property (@(posedge clk) disable iff (rst)
    (test_count <= CNT_W'(MAX_SAMPLES)) && (normal_count <= CNT_W'(MAX_SAMPLES)))
    else $error("phase count beyond sample limit");

endmodule

>>> rtl/core/ast_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module ast_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ast_pkg::DIV_W-1:0]   dividend,
  input  logic [ast_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [ast_pkg::DIV_W-1:0]   quotient
);
  import ast_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              qbit;
  logic [CNT_W-1:0]  rem_next;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial    = {rem, dvd[DIV_W-1]};
    diff     = trial - {1'b0, dsr};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  // Iteration control; quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= rem_next;
        dvd  <= {dvd[DIV_W-2:0], qbit};
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

>>> rtl/core/ast_lane.sv
// One axis lane: phase sums, and the average and relative change sequence on a shared divider.
module ast_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  ast_pkg::lane_ctrl_t              ctrl,
  input  logic signed [ast_pkg::ACC_W-1:0] accel,
  input  logic [ast_pkg::CODE_W-1:0]       code,
  input  logic [ast_pkg::CNT_W-1:0]        test_count,
  input  logic [ast_pkg::CNT_W-1:0]        normal_count,
  input  logic [ast_pkg::TOL_W-1:0]        tolerance,
  output ast_pkg::lane_status_t            status
);
  import ast_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_TEST = 3'd1;
  localparam logic [2:0] L_NORM = 3'd2;
  localparam logic [2:0] L_CHG  = 3'd3;
  localparam logic [2:0] L_HOLD = 3'd4;

  localparam logic [DIV_W-1:0] POS_MAX = DIV_W'((1 << (CHG_W - 1)) - 1);
  localparam logic [DIV_W-1:0] NEG_MAG = DIV_W'(1 << (CHG_W - 1));

  logic [2:0]              state;
  logic [SUM_W-1:0]        test_sum;
  logic [SUM_W-1:0]        normal_sum;
  logic [CODE_W-1:0]       code_q;
  logic signed [AVG_W-1:0] avg_t;
  logic                    div_neg;
  logic                    pass_q;
  logic signed [CHG_W-1:0] change_q;

  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [CNT_W-1:0]        div_divisor;
  logic                    div_sign;
  logic                    div_done;
  logic [DIV_W-1:0]        quot;

  logic [DIV_W-1:0]        q_signed;
  logic signed [AVG_W-1:0] avg_t_calc;
  logic signed [AVG_W-1:0] avg_n_calc;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] dev;
  logic [DIFF_W-1:0]       dev_mag;
  logic [FT_W-1:0]         ft;
  logic signed [CHG_W-1:0] change_calc;
  logic [CHG_W:0]          change_mag;
  logic                    pass_calc;

  function automatic logic [SUM_W-1:0] mag32(input logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  ast_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // Averages, deviation from the factory response, and saturation
  always_comb begin
    q_signed   = div_neg ? (~quot + 1'b1) : quot;
    avg_t_calc = (test_count == '0) ? '0 : $signed(q_signed[AVG_W-1:0]);
    avg_n_calc = (normal_count == '0) ? '0 : $signed(q_signed[AVG_W-1:0]);
    diff       = $signed({avg_t[AVG_W-1], avg_t}) - $signed({avg_n_calc[AVG_W-1], avg_n_calc});
    ft         = ft_lookup(code_q);
    dev        = diff - $signed({{(DIFF_W - FT_W){1'b0}}, ft});
    dev_mag    = dev[DIFF_W-1] ? DIFF_W'(-dev) : DIFF_W'(dev);
    if (!div_neg) begin
      if (quot > POS_MAX) begin
        change_calc = CHG_W'(POS_MAX);
        change_mag  = (CHG_W + 1)'(POS_MAX);
      end else begin
        change_calc = $signed(quot[CHG_W-1:0]);
        change_mag  = quot[CHG_W:0];
      end
    end else begin
      if (quot >= NEG_MAG) begin
        change_calc = $signed(CHG_W'(NEG_MAG));
        change_mag  = (CHG_W + 1)'(NEG_MAG);
      end else begin
        change_calc = $signed(~quot[CHG_W-1:0] + 1'b1);
        change_mag  = quot[CHG_W:0];
      end
    end
    pass_calc = (change_mag <= {2'b00, tolerance});
    if (code_q == '0) begin
      change_calc = $signed(CHG_W'(NEG_MAG));
      pass_calc   = 1'b0;
    end
  end

  // Divider operand select per step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_sign     = 1'b0;
    unique case (state)
      L_IDLE: begin
        if (ctrl.start) begin
          div_start    = 1'b1;
          div_dividend = mag32(test_sum);
          div_divisor  = test_count;
          div_sign     = test_sum[SUM_W-1];
        end
      end
      L_TEST: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = mag32(normal_sum);
          div_divisor  = normal_count;
          div_sign     = normal_sum[SUM_W-1];
        end
      end
      L_NORM: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'({dev_mag, {Q_FRAC{1'b0}}});
          div_divisor  = CNT_W'(ft);
          div_sign     = dev[DIFF_W-1];
        end
      end
      default: ;
    endcase
  end

  // Sequencer and phase sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= L_IDLE;
      test_sum   <= '0;
      normal_sum <= '0;
    end else begin
      if (div_start) begin
        div_neg <= div_sign;
      end
      unique case (state)
        L_IDLE: begin
          if (ctrl.acc_test) begin
            test_sum <= test_sum + SUM_W'(accel);
          end
          if (ctrl.acc_norm) begin
            normal_sum <= normal_sum + SUM_W'(accel);
          end
          if (ctrl.start) begin
            code_q <= code;
            state  <= L_TEST;
          end
        end
        L_TEST: begin
          if (div_done) begin
            avg_t <= avg_t_calc;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (div_done) begin
            state <= L_CHG;
          end
        end
        L_CHG: begin
          if (div_done) begin
            pass_q   <= pass_calc;
            change_q <= change_calc;
            state    <= L_HOLD;
          end
        end
        L_HOLD: begin
          if (ctrl.take) begin
            test_sum   <= '0;
            normal_sum <= '0;
            state      <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign status.done   = (state == L_HOLD);
  assign status.pass   = pass_q;
  assign status.change = change_q;

endmodule

>>> rtl/core/ast_merge.sv
// Merge stage: joins the three lane results into the output register.
module ast_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  ast_pkg::lane_status_t [2:0]         st,
  output logic                                take,
  ast_result_if.source                        result
);
  import ast_pkg::*;

  logic all_done;

  // Load when every lane is finished and the output slot is free
  assign all_done = st[0].done & st[1].done & st[2].done;
  assign take     = all_done && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      if (take) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      result.pass_x   <= st[0].pass;
      result.pass_y   <= st[1].pass;
      result.pass_z   <= st[2].pass;
      result.change_x <= st[0].change;
      result.change_y <= st[1].change;
      result.change_z <= st[2].change;
    end
  end

endmodule

>>> tb/testbench.sv
// Self-test evaluator testbench: directed request table, then random sample/evaluate rounds.
module testbench;
  import ast_pkg::*;

  localparam int PHASE_LIMIT = MAX_SAMPLES_DEF;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASE_REQS = 40;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  // Factory response per trim code, LSB; code 0 has no trim
  localparam int FT_LSB [32] = '{
    0,
    1393, 1440, 1488, 1538, 1590, 1644, 1699, 1757,
    1816, 1877, 1941, 2006, 2074, 2144, 2216, 2291,
    2368, 2448, 2531, 2616, 2704, 2795, 2890, 2987,
    3088, 3192, 3300, 3411, 3526, 3645, 3768
  };

  // Index 0 is x, 1 is y, 2 is z
  typedef struct packed {
    logic [1:0]                   func;
    logic [2:0][ACC_W-1:0]        accel;
    logic [2:0][TRIM_W-1:0]       trim;
    logic [TRIM_W-1:0]            trim_low;
  } st_req_t;

  typedef struct packed {
    logic [2:0]                   pass_ok;
    logic [2:0][CHG_W-1:0]        change;
  } verdict_t;

  typedef struct {
    st_req_t  req;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_wdata;

  ast_sample_if smp ();
  ast_result_if res ();

  accel_self_test_evaluator_core #(
    .MAX_SAMPLES(PHASE_LIMIT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .sample(smp),
    .result(res),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [SUM_W-1:0] test_sum [3];
  logic [SUM_W-1:0] norm_sum [3];
  int               test_cnt;
  int               norm_cnt;
  int               tol_q12;

  verdict_t verdict_q [$];
  int       fail_count;
  int       req_count;
  int       snd_idle_pct;
  int       rcv_idle_pct;
  string    axis_name [3] = '{"x", "y", "z"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic [ACC_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic st_req_t smp_req(input logic [1:0] f, input int x, input int y,
                                      input int z);
    st_req_t r;
    r = '0;
    r.func = f;
    r.accel[0] = 16'(x);
    r.accel[1] = 16'(y);
    r.accel[2] = 16'(z);
    return r;
  endfunction

  function automatic st_req_t eval_req(input logic [7:0] tx, input logic [7:0] ty,
                                       input logic [7:0] tz, input logic [7:0] tl);
    st_req_t r;
    r = '0;
    r.func = FUNC_EVAL;
    r.trim[0] = tx;
    r.trim[1] = ty;
    r.trim[2] = tz;
    r.trim_low = tl;
    return r;
  endfunction

  // p[0] is x
  function automatic verdict_t make_verdict(input logic [2:0] p, input int cx,
                                            input int cy, input int cz);
    verdict_t v;
    v.pass_ok = p;
    v.change[0] = 16'(cx);
    v.change[1] = 16'(cy);
    v.change[2] = 16'(cz);
    return v;
  endfunction

  // Apply one accepted request to the local state; returns 1 if it yields a verdict
  function automatic bit predict_verdict(input st_req_t r, output verdict_t v);
    logic [CODE_W-1:0] code;
    longint test_avg, norm_avg, diff, ft, q, mag;
    v = '0;
    if (r.func == FUNC_TEST && test_cnt < PHASE_LIMIT) begin
      for (int k = 0; k < 3; k++)
        test_sum[k] = test_sum[k] + {{16{r.accel[k][15]}}, r.accel[k]};
      test_cnt++;
    end
    if (r.func == FUNC_NORM && norm_cnt < PHASE_LIMIT) begin
      for (int k = 0; k < 3; k++)
        norm_sum[k] = norm_sum[k] + {{16{r.accel[k][15]}}, r.accel[k]};
      norm_cnt++;
    end
    if (r.func != FUNC_EVAL) return 1'b0;

    for (int k = 0; k < 3; k++) begin
      code = {r.trim[k][7:5], r.trim_low[5-2*k -: 2]};
      if (code == 0) begin
        // no factory trim: forced fail
        v.pass_ok[k] = 1'b0;
        v.change[k] = 16'h8000;
      end else begin
        test_avg = (test_cnt == 0) ? 0 : longint'($signed(test_sum[k])) / longint'(test_cnt);
        norm_avg = (norm_cnt == 0) ? 0 : longint'($signed(norm_sum[k])) / longint'(norm_cnt);
        diff = test_avg - norm_avg;
        ft = FT_LSB[code];
        q = ((diff - ft) * 4096) / ft;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        mag = (q < 0) ? -q : q;
        v.pass_ok[k] = (mag <= tol_q12);
        v.change[k] = q[15:0];
      end
    end

    for (int k = 0; k < 3; k++) begin
      test_sum[k] = '0;
      norm_sum[k] = '0;
    end
    test_cnt = 0;
    norm_cnt = 0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Present one request, wait for the handshake, then predict
  task automatic send_req(input st_req_t r, input bit typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < snd_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid            <= 1'b1;
    smp.func             <= r.func;
    smp.accel_x          <= r.accel[0];
    smp.accel_y          <= r.accel[1];
    smp.accel_z          <= r.accel[2];
    smp.trim_byte_x      <= r.trim[0];
    smp.trim_byte_y      <= r.trim[1];
    smp.trim_byte_z      <= r.trim[2];
    smp.trim_byte_shared <= r.trim_low;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    if (predict_verdict(r, v)) verdict_q.push_back(typed ? want : v);
    if (r.func != FUNC_RSVD) req_count++;
  endtask

  // Write the tolerance once the block has gone quiet
  task automatic set_tolerance(input int value);
    smp.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[TOL_W-1:0];
    @(posedge clk);
    cfg_we  <= 1'b0;
    tol_q12 = value;
  endtask

  // One collection round: samples of both phases, reserved noise, then an evaluate.
  // Shaped rounds aim the measured response near the factory value.
  task automatic run_round(input int n_test, input int n_norm, input bit shaped);
    logic [CODE_W-1:0] code [3];
    int                nbase [3];
    int                resp [3];
    int                noise;
    bit                to_test;
    st_req_t           r;
    logic [TRIM_W-1:0] trim_low;
    trim_low = 8'($urandom);
    noise = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 40));
    for (int k = 0; k < 3; k++) begin
      code[k]  = ($urandom_range(15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
      nbase[k] = int'($urandom_range(0, 16000)) - 8000;
      resp[k]  = FT_LSB[code[k]] +
                 FT_LSB[code[k]] * (int'($urandom_range(0, 2400)) - 1200) / 4096;
    end

    while (n_test + n_norm > 0) begin
      r = '0;
      if ($urandom_range(19) == 0) begin
        r.func = FUNC_RSVD;
        r.accel = 48'({$urandom, $urandom});
      end else begin
        to_test = (n_norm == 0) || (n_test > 0 && $urandom_range(1) == 1);
        r.func = to_test ? FUNC_TEST : FUNC_NORM;
        if (to_test) n_test--;
        else n_norm--;
        for (int k = 0; k < 3; k++)
          r.accel[k] = shaped ? clamp16(nbase[k] + (to_test ? resp[k] : 0) +
                                        int'($urandom_range(0, 2 * noise)) - noise)
                              : 16'($urandom);
      end
      r.trim = 24'($urandom);
      r.trim_low = 8'($urandom);
      send_req(r, 1'b0, '0);
    end

    r = '0;
    r.func = FUNC_EVAL;
    r.accel = 48'({$urandom, $urandom});
    for (int k = 0; k < 3; k++) begin
      r.trim[k] = shaped ? {code[k][4:2], 5'($urandom)} : 8'($urandom);
      if (shaped) trim_low[5-2*k -: 2] = code[k][1:0];
    end
    r.trim_low = trim_low;
    send_req(r, 1'b0, '0);
  endtask

  // Result sink back-pressure
  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each delivered verdict with the oldest prediction
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && res.valid && res.ready) begin
      got.pass_ok = {res.pass_z, res.pass_y, res.pass_x};
      got.change  = {res.change_z, res.change_y, res.change_x};
      if (verdict_q.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          check_field({"pass_", axis_name[k]}, want.pass_ok[k], got.pass_ok[k]);
          check_field({"change_", axis_name[k]}, $signed(want.change[k]),
                      $signed(got.change[k]));
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    int       tol_set [6];
    int       phase_start;

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    smp.valid            <= 1'b0;
    smp.func             <= FUNC_TEST;
    smp.accel_x          <= '0;
    smp.accel_y          <= '0;
    smp.accel_z          <= '0;
    smp.trim_byte_x      <= '0;
    smp.trim_byte_y      <= '0;
    smp.trim_byte_z      <= '0;
    smp.trim_byte_shared <= '0;
    fail_count   = 0;
    req_count    = 0;
    snd_idle_pct = 6;
    rcv_idle_pct = 55;
    tol_q12      = TOL_RESET;
    test_cnt     = 0;
    norm_cnt     = 0;
    for (int k = 0; k < 3; k++) begin
      test_sum[k] = '0;
      norm_sum[k] = '0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests, reset tolerance of 573
    // empty phases: x has no trim, y code 31, z code 1
    dir_rows.push_back('{eval_req(8'h00, 8'hFF, 8'h1F, 8'h0D), 1'b1,
                         make_verdict(3'b000, -32768, -4096, -4096)});
    // largest positive response saturates
    dir_rows.push_back('{smp_req(FUNC_TEST, 32767, 32767, 32767), 1'b0, '0});
    dir_rows.push_back('{smp_req(FUNC_NORM, -32768, -32768, -32768), 1'b0, '0});
    dir_rows.push_back('{eval_req(8'h1F, 8'h1F, 8'h1F, 8'h15), 1'b1,
                         make_verdict(3'b000, 32767, 32767, 32767)});
    // largest negative response saturates
    dir_rows.push_back('{smp_req(FUNC_TEST, -32768, -32768, -32768), 1'b0, '0});
    dir_rows.push_back('{smp_req(FUNC_NORM, 32767, 32767, 32767), 1'b0, '0});
    dir_rows.push_back('{eval_req(8'hFF, 8'hFF, 8'hFF, 8'h3F), 1'b1,
                         make_verdict(3'b000, -32768, -32768, -32768)});
    // exact factory response with no normal samples; reserved request ignored
    dir_rows.push_back('{smp_req(FUNC_TEST, 1393, 3768, 0), 1'b0, '0});
    dir_rows.push_back('{smp_req(FUNC_RSVD, -32768, 32767, 21845), 1'b0, '0});
    dir_rows.push_back('{eval_req(8'h00, 8'hE0, 8'h00, 8'h1C), 1'b1,
                         make_verdict(3'b011, 0, 0, -32768)});
    // truncating averages of mixed sign
    dir_rows.push_back('{smp_req(FUNC_NORM, 100, -200, 300), 1'b0, '0});
    dir_rows.push_back('{smp_req(FUNC_NORM, -101, 203, 1), 1'b0, '0});
    dir_rows.push_back('{smp_req(FUNC_TEST, 1600, 1300, 2500), 1'b0, '0});
    dir_rows.push_back('{smp_req(FUNC_TEST, 1601, -1300, -2501), 1'b0, '0});
    dir_rows.push_back('{eval_req(8'hA5, 8'h5A, 8'h3C, 8'hC9), 1'b0, '0});
    // no self-test samples
    dir_rows.push_back('{smp_req(FUNC_NORM, -5, 7, -9), 1'b0, '0});
    dir_rows.push_back('{eval_req(8'h60, 8'h80, 8'hC0, 8'h36), 1'b0, '0});
    // sums were cleared by the previous evaluate
    dir_rows.push_back('{eval_req(8'h20, 8'h40, 8'h60, 8'hFF), 1'b1,
                         make_verdict(3'b000, -4096, -4096, -4096)});

    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random rounds, one tolerance setting per phase
    tol_set = '{32767, 0, 573, int'($urandom_range(0, 32767)), 1,
                int'($urandom_range(0, 4095))};
    for (int phase = 0; phase < 6; phase++) begin
      set_tolerance(tol_set[phase]);
      snd_idle_pct = (phase / 2 == 0) ? 6 : (phase / 2 == 1) ? 55 : 0;
      rcv_idle_pct = (phase / 2 == 0) ? 55 : (phase / 2 == 1) ? 6 : 0;
      phase_start = req_count;
      // overrun the self-test phase past the sample limit once
      if (phase == 5) run_round(PHASE_LIMIT + 12, 4, 1'b1);
      while (req_count - phase_start < PHASE_REQS)
        run_round($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(3) != 0);
    end

    // Drain
    smp.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> accel_self_test_evaluator_core.f
rtl/core/ast_pkg.sv
rtl/core/ast_sample_if.sv
rtl/core/ast_result_if.sv
rtl/core/ast_div.sv
rtl/core/ast_lane.sv
rtl/core/ast_merge.sv
rtl/core/accel_self_test_evaluator_core.sv
tb/testbench.sv
